@@ design/sm83alu_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sm83alu_pkg
// Shared types and constants of the SM83 ALU: operation codes, flag bit
// positions and the words passed between the ALU core and the top level.
// ----------------------------------------------------------------------------
package sm83alu_pkg;

   localparam int DATA_W  = 8;
   localparam int FLAGS_W = 4;
   localparam int KIND_W  = 5;
   localparam int BIT_W   = 3;

   // Flag bit positions inside a flags word.
   localparam int FLAG_Z = 3;
   localparam int FLAG_N = 2;
   localparam int FLAG_H = 1;
   localparam int FLAG_C = 0;

   // Decimal adjust constants.
   localparam logic [DATA_W-1:0] DAA_HIGH_LIMIT = 8'h99;
   localparam logic [DATA_W-1:0] DAA_HIGH_ADJ   = 8'h60;
   localparam logic [DATA_W-1:0] DAA_LOW_ADJ    = 8'h06;
   localparam logic [3:0]        DAA_LOW_LIMIT  = 4'h9;

   typedef enum logic [KIND_W-1:0] {
      KIND_ADD  = 5'd0,
      KIND_ADC  = 5'd1,
      KIND_SUB  = 5'd2,
      KIND_SBC  = 5'd3,
      KIND_AND  = 5'd4,
      KIND_XOR  = 5'd5,
      KIND_OR   = 5'd6,
      KIND_CP   = 5'd7,
      KIND_INC  = 5'd8,
      KIND_DEC  = 5'd9,
      KIND_RLCA = 5'd10,
      KIND_RRCA = 5'd11,
      KIND_RLA  = 5'd12,
      KIND_RRA  = 5'd13,
      KIND_DAA  = 5'd14,
      KIND_CPL  = 5'd15,
      KIND_SCF  = 5'd16,
      KIND_CCF  = 5'd17,
      KIND_RLC  = 5'd18,
      KIND_RRC  = 5'd19,
      KIND_RL   = 5'd20,
      KIND_RR   = 5'd21,
      KIND_SLA  = 5'd22,
      KIND_SRA  = 5'd23,
      KIND_SWAP = 5'd24,
      KIND_SRL  = 5'd25,
      KIND_BIT  = 5'd26,
      KIND_RES  = 5'd27,
      KIND_SET  = 5'd28
   } kind_type;

   typedef struct packed {
      kind_type            kind;
      logic [DATA_W-1:0]   operand_a;
      logic [DATA_W-1:0]   operand_b;
      logic [BIT_W-1:0]    bit_index;
      logic [FLAGS_W-1:0]  flags_in;
   } alu_op_type;

   typedef struct packed {
      logic [DATA_W-1:0]   result;
      logic [FLAGS_W-1:0]  flags_out;
      logic                write_back;
   } alu_res_type;

endpackage
`default_nettype wire

@@ design/sm83alu_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sm83alu_core
// Combinational SM83 ALU: separate add and subtract paths, increment,
// decrement, rotates, shifts, decimal adjust and bit operations, with flag generation.
// ----------------------------------------------------------------------------
module sm83alu_core
   import sm83alu_pkg::*;
(
   input  wire alu_op_type op,
   output alu_res_type     res
);

   logic [DATA_W-1:0] a;
   logic [DATA_W-1:0] b;
   logic              cin;
   logic              nin;
   logic              hin;
   logic              carry_t;
   logic [DATA_W:0]   sum_full;
   logic [4:0]        sum_half;
   logic [DATA_W:0]   diff_full;
   logic [4:0]        diff_half;
   logic [DATA_W-1:0] inc_val;
   logic [DATA_W-1:0] dec_val;
   logic [DATA_W-1:0] daa_adj;
   logic              daa_carry;
   logic [DATA_W-1:0] daa_val;
   logic [DATA_W-1:0] bit_mask;

   assign a   = op.operand_a;
   assign b   = op.operand_b;
   assign cin = op.flags_in[FLAG_C];
   assign nin = op.flags_in[FLAG_N];
   assign hin = op.flags_in[FLAG_H];

   // Carry/borrow-in is used only by the with-carry forms.
   assign carry_t = ((op.kind == KIND_ADC) || (op.kind == KIND_SBC)) ? cin : 1'b0;

   assign sum_full  = {1'b0, a} + {1'b0, b} + {{DATA_W{1'b0}}, carry_t};
   assign sum_half  = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'b0, carry_t};
   assign diff_full = {1'b0, a} - {1'b0, b} - {{DATA_W{1'b0}}, carry_t};
   assign diff_half = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'b0, carry_t};

   assign inc_val = a + 8'd1;
   assign dec_val = a - 8'd1;

   always_comb begin
      daa_adj   = '0;
      daa_carry = 1'b0;
      if (hin || (!nin && (a[3:0] > DAA_LOW_LIMIT))) begin
         daa_adj = DAA_LOW_ADJ;
      end
      if (cin || (!nin && (a > DAA_HIGH_LIMIT))) begin
         daa_adj   = daa_adj | DAA_HIGH_ADJ;
         daa_carry = 1'b1;
      end
   end

   assign daa_val  = nin ? (a - daa_adj) : (a + daa_adj);
   assign bit_mask = 8'd1 << op.bit_index;

   always_comb begin
      logic [DATA_W-1:0] r;
      logic [FLAGS_W-1:0] f;
      logic wb;
      r  = a;
      f  = op.flags_in;
      wb = 1'b1;
      case (op.kind)
         KIND_ADD, KIND_ADC: begin
            r = sum_full[DATA_W-1:0];
            f = {r == '0, 1'b0, sum_half[4], sum_full[DATA_W]};
         end
         KIND_SUB, KIND_SBC, KIND_CP: begin
            r = diff_full[DATA_W-1:0];
            f = {r == '0, 1'b1, diff_half[4], diff_full[DATA_W]};
            // Compare keeps the accumulator and only sets flags.
            if (op.kind == KIND_CP) begin
               r  = a;
               wb = 1'b0;
            end
         end
         KIND_AND: begin
            r = a & b;
            f = {r == '0, 1'b0, 1'b1, 1'b0};
         end
         KIND_XOR: begin
            r = a ^ b;
            f = {r == '0, 3'b000};
         end
         KIND_OR: begin
            r = a | b;
            f = {r == '0, 3'b000};
         end
         KIND_INC: begin
            r = inc_val;
            f = {r == '0, 1'b0, r[3:0] == 4'h0, cin};
         end
         KIND_DEC: begin
            r = dec_val;
            f = {r == '0, 1'b1, r[3:0] == 4'hF, cin};
         end
         KIND_RLCA: begin
            r = {a[6:0], a[7]};
            f = {3'b000, a[7]};
         end
         KIND_RRCA: begin
            r = {a[0], a[7:1]};
            f = {3'b000, a[0]};
         end
         KIND_RLA: begin
            r = {a[6:0], cin};
            f = {3'b000, a[7]};
         end
         KIND_RRA: begin
            r = {cin, a[7:1]};
            f = {3'b000, a[0]};
         end
         KIND_DAA: begin
            r = daa_val;
            f = {r == '0, nin, 1'b0, daa_carry};
         end
         KIND_CPL: begin
            r = ~a;
            f = {op.flags_in[FLAG_Z], 1'b1, 1'b1, cin};
         end
         KIND_SCF: begin
            wb = 1'b0;
            f  = {op.flags_in[FLAG_Z], 2'b00, 1'b1};
         end
         KIND_CCF: begin
            wb = 1'b0;
            f  = {op.flags_in[FLAG_Z], 2'b00, ~cin};
         end
         KIND_RLC: begin
            r = {a[6:0], a[7]};
            f = {r == '0, 2'b00, a[7]};
         end
         KIND_RRC: begin
            r = {a[0], a[7:1]};
            f = {r == '0, 2'b00, a[0]};
         end
         KIND_RL: begin
            r = {a[6:0], cin};
            f = {r == '0, 2'b00, a[7]};
         end
         KIND_RR: begin
            r = {cin, a[7:1]};
            f = {r == '0, 2'b00, a[0]};
         end
         KIND_SLA: begin
            r = {a[6:0], 1'b0};
            f = {r == '0, 2'b00, a[7]};
         end
         KIND_SRA: begin
            r = {a[7], a[7:1]};
            f = {r == '0, 2'b00, a[0]};
         end
         KIND_SWAP: begin
            r = {a[3:0], a[7:4]};
            f = {r == '0, 3'b000};
         end
         KIND_SRL: begin
            r = {1'b0, a[7:1]};
            f = {r == '0, 2'b00, a[0]};
         end
         KIND_BIT: begin
            wb = 1'b0;
            f  = {(a & bit_mask) == '0, 1'b0, 1'b1, cin};
         end
         KIND_RES: begin
            r = a & ~bit_mask;
         end
         KIND_SET: begin
            r = a | bit_mask;
         end
         default: begin
            // Unassigned codes pass the operand and flags through untouched.
            wb = 1'b0;
         end
      endcase
      res.result     = r;
      res.flags_out  = f;
      res.write_back = wb;
   end

endmodule
`default_nettype wire

@@ design/sm83_alu_with_flags_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sm83_alu_with_flags_unit
// SM83 ALU with flags: input register, combinational ALU core, result
// register with a one-cycle result strobe.
// ----------------------------------------------------------------------------
// A word accepted into the input register is on the rsp_ ports, with rsp_valid
// high, for a single cycle once the result register has taken it.
// Throughput: one word per cycle; busy is tied low. The input and
// result registers sit around a single pass of the ALU core.
// The receiver cannot stall; every result is taken in its strobe cycle.
// Reset (synchronous, active high) clears both valid bits; data is not reset.
module sm83_alu_with_flags_unit
   import sm83alu_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output      logic               busy,
   input  wire logic [KIND_W-1:0]  req_kind,
   input  wire logic [DATA_W-1:0]  req_operand_a,
   input  wire logic [DATA_W-1:0]  req_operand_b,
   input  wire logic [BIT_W-1:0]   req_bit_index,
   input  wire logic [FLAGS_W-1:0] req_flags_in,
   output      logic               rsp_valid,
   output      logic [DATA_W-1:0]  rsp_result,
   output      logic [FLAGS_W-1:0] rsp_flags_out,
   output      logic               rsp_write_back
);

   logic        accept;
   logic        stage_valid_ff;
   logic        stage_valid_in;
   alu_op_type  stage_op_ff;
   alu_op_type  stage_op_in;
   alu_res_type core_res;
   logic        rsp_valid_ff;
   logic        rsp_valid_in;
   alu_res_type rsp_res_ff;
   alu_res_type rsp_res_in;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   assign stage_valid_in = accept;
   assign stage_op_in    = '{kind:      kind_type'(req_kind),
                             operand_a: req_operand_a,
                             operand_b: req_operand_b,
                             bit_index: req_bit_index,
                             flags_in:  req_flags_in};

   sm83alu_core u_core (
      .op  (stage_op_ff),
      .res (core_res)
   );

   assign rsp_valid_in = stage_valid_ff;
   assign rsp_res_in   = core_res;

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      if (accept) begin
         stage_op_ff <= stage_op_in;
      end
      if (stage_valid_ff) begin
         rsp_res_ff <= rsp_res_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_result     = rsp_res_ff.result;
   assign rsp_flags_out  = rsp_res_ff.flags_out;
   assign rsp_write_back = rsp_res_ff.write_back;

   // Every strobe comes from a word that was held in the input register.
   a_rsp_from_stage: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(stage_valid_ff))
      else $error("result strobe without a staged word");

   // An accepted word reaches the result ports through the input and result registers.
   a_accept_to_rsp: assert property (@(posedge clock) disable iff (reset)
      accept |=> ##1 rsp_valid_ff)
      else $error("accepted word produced no result strobe");

   // Compare, bit test and carry flag operations never write back.
   a_no_wb_kinds: assert property (@(posedge clock) disable iff (reset)
      (stage_valid_ff && (stage_op_ff.kind == KIND_CP || stage_op_ff.kind == KIND_BIT ||
       stage_op_ff.kind == KIND_SCF || stage_op_ff.kind == KIND_CCF))
      |=> (!rsp_write_back && rsp_result == $past(stage_op_ff.operand_a)))
      else $error("flag-only operation marked for write-back");

endmodule
`default_nettype wire
